// ===== sv/snoop_coherence_responder_core_macros.svh =====
// Assertion macros shared by the snoop responder's checker.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef SNOOP_COHERENCE_RESPONDER_CORE_MACROS_SVH
`define SNOOP_COHERENCE_RESPONDER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SCR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/scr_pkg.sv =====
// Shared types and codes for the snoop coherence responder.
// No dependencies; used by every module of the block.
package scr_pkg;

  // Transaction kinds.
  localparam logic [2:0] KIND_READ      = 3'd0;
  localparam logic [2:0] KIND_READ_EX   = 3'd1;
  localparam logic [2:0] KIND_UPGRADE   = 3'd2;
  localparam logic [2:0] KIND_UPDATE    = 3'd3;
  localparam logic [2:0] KIND_RD_COUNTS = 3'd4;

  // Line state encoding, three bits per cache.
  localparam logic [2:0] ST_INVALID    = 3'd0;
  localparam logic [2:0] ST_SHARED     = 3'd1;
  localparam logic [2:0] ST_EXCLUSIVE  = 3'd2;
  localparam logic [2:0] ST_MODIFIED   = 3'd3;
  localparam logic [2:0] ST_SHARED_MOD = 3'd4;

  // Protocol mode value that selects the update protocol.
  localparam logic [1:0] PROTO_UPDATE = 2'd2;

  // Configuration register indexes (taken from paddr bit 2).
  localparam logic REG_PROTOCOL_MODE     = 1'b0;
  localparam logic REG_ACTIVE_PROCESSORS = 1'b1;

  // Widths fixed by the interface.
  localparam int NUM_SLOTS = 8;
  localparam int ST_W      = 3;
  localparam int CNT_W     = 32;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  requester;
    logic [31:0] line_address;
    logic [23:0] line_states;
    logic [7:0]  present_mask;
  } in_word_t;

  typedef struct packed {
    logic [23:0] new_states;
    logic [31:0] echo_address;
    logic        copy_exists;
    logic [7:0]  intervention_mask;
    logic [7:0]  flush_mask;
    logic [7:0]  invalidation_mask;
    logic [7:0]  writeback_mask;
    logic [31:0] count_interventions;
    logic [31:0] count_flushes;
    logic [31:0] count_invalidations;
    logic [31:0] count_writebacks;
  } out_word_t;

  // Actions one cache performs for one transaction.
  typedef struct packed {
    logic iv;
    logic fl;
    logic inv;
    logic wb;
  } lane_act_t;

  // Event counters held by one lane.
  typedef struct packed {
    logic [CNT_W-1:0] ivc;
    logic [CNT_W-1:0] flc;
    logic [CNT_W-1:0] invc;
    logic [CNT_W-1:0] wbc;
  } lane_cnt_t;

endpackage

// ===== sv/scr_lane.sv =====
// One snooping cache's lane: coherence rules and that cache's event counters.
// Depends on scr_pkg.
module scr_lane (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   snoop,
  input  logic                   fire,
  input  logic                   upd,
  input  logic [2:0]             kind,
  input  logic [scr_pkg::ST_W-1:0] state_in,
  output logic [scr_pkg::ST_W-1:0] state_out,
  output scr_pkg::lane_act_t     act,
  output scr_pkg::lane_cnt_t     cnt
);
  import scr_pkg::*;

  lane_cnt_t cnt_r, cnt_nxt;

  // Per-cache transition rules for the snooped transaction.
  always_comb begin
    state_out = state_in;
    act       = '0;
    if (snoop) begin
      case (kind)
        KIND_READ: begin
          if (state_in == ST_EXCLUSIVE) begin
            state_out = ST_SHARED;
            act.iv    = 1'b1;
          end else if (state_in == ST_MODIFIED) begin
            act.iv = 1'b1;
            act.fl = 1'b1;
            if (upd) begin
              state_out = ST_SHARED_MOD;
            end else begin
              state_out = ST_SHARED;
              act.wb    = 1'b1;
            end
          end else if (state_in == ST_SHARED_MOD && upd) begin
            act.fl = 1'b1;
          end
        end
        KIND_READ_EX: begin
          if (state_in == ST_MODIFIED) begin
            state_out = ST_INVALID;
            act.wb    = 1'b1;
            act.inv   = 1'b1;
            act.fl    = 1'b1;
          end else if (state_in inside {ST_SHARED, ST_EXCLUSIVE}) begin
            state_out = ST_INVALID;
            act.inv   = 1'b1;
          end
        end
        KIND_UPGRADE: begin
          if (state_in == ST_SHARED) begin
            state_out = ST_INVALID;
            act.inv   = 1'b1;
          end
        end
        KIND_UPDATE: begin
          if (state_in == ST_SHARED_MOD) begin
            state_out = ST_SHARED;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Counters advance on the accepting edge; they wrap at 2^32.
  always_comb begin
    cnt_nxt = cnt_r;
    if (fire) begin
      if (act.iv)  cnt_nxt.ivc  = cnt_r.ivc + CNT_W'(1);
      if (act.fl)  cnt_nxt.flc  = cnt_r.flc + CNT_W'(1);
      if (act.inv) cnt_nxt.invc = cnt_r.invc + CNT_W'(1);
      if (act.wb)  cnt_nxt.wbc  = cnt_r.wbc + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign cnt = cnt_r;

endmodule

// ===== sv/scr_merge.sv =====
// Merging stage: gathers lane states and actions into one result word.
// Depends on scr_pkg; fed by the scr_lane instances.
module scr_merge #(
  parameter int MAX_PROCESSORS = 8
) (
  input  scr_pkg::in_word_t  in_word,
  input  logic [MAX_PROCESSORS-1:0] snoop,
  input  logic [scr_pkg::ST_W-1:0] lane_state [MAX_PROCESSORS],
  input  scr_pkg::lane_act_t lane_act [MAX_PROCESSORS],
  input  scr_pkg::lane_cnt_t lane_cnt [MAX_PROCESSORS],
  output scr_pkg::out_word_t res
);
  import scr_pkg::*;

  localparam int IDX_W = (MAX_PROCESSORS > 1) ? $clog2(MAX_PROCESSORS) : 1;

  lane_cnt_t sel_cnt;

  // Counter readback for the requester, zero for any other kind or an out-of-range requester.
  always_comb begin
    sel_cnt = '0;
    if (in_word.kind == KIND_RD_COUNTS && 32'(in_word.requester) < MAX_PROCESSORS) begin
      sel_cnt = lane_cnt[in_word.requester[IDX_W-1:0]];
    end
  end

  // Slots beyond the lane count echo their state and take no action.
  always_comb begin
    res                   = '0;
    res.new_states        = in_word.line_states;
    res.echo_address      = in_word.line_address;
    res.copy_exists       = |snoop;
    for (int i = 0; i < MAX_PROCESSORS; i++) begin
      res.new_states[ST_W*i +: ST_W] = lane_state[i];
      res.intervention_mask[i]       = lane_act[i].iv;
      res.flush_mask[i]              = lane_act[i].fl;
      res.invalidation_mask[i]       = lane_act[i].inv;
      res.writeback_mask[i]          = lane_act[i].wb;
    end
    res.count_interventions = sel_cnt.ivc;
    res.count_flushes       = sel_cnt.flc;
    res.count_invalidations = sel_cnt.invc;
    res.count_writebacks    = sel_cnt.wbc;
  end

endmodule

// ===== sv/snoop_coherence_responder_core.sv =====
// Snoop coherence responder, top level: config registers, lanes, merge and output buffer.
// Depends on scr_pkg, scr_lane and scr_merge.
//
// The responder takes one snooped word per clock while in_ready is high and returns one
// result word per input through the output register. Every cache has its own lane
// that applies the MSI/MESI or update-protocol rules and keeps that cache's four event
// counters; all lanes evaluate in the accepting cycle and a merge stage builds the result,
// which lands in an output register backed by a one-word skid buffer, so in_ready drops
// only when both hold a word. Counter increments take effect at the accepting edge, so a
// read-counters word sees every word accepted before it. Configuration (protocol_mode at
// byte address 0, active_processors at 4) must be written while no word is in flight.
module snoop_coherence_responder_core #(
  parameter int MAX_PROCESSORS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  scr_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output scr_pkg::out_word_t out_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import scr_pkg::*;

  logic [1:0] protocol_mode_r;
  logic [3:0] active_procs_r;

  logic       in_acc;
  logic       upd;
  logic [MAX_PROCESSORS-1:0] snoop;
  logic [ST_W-1:0] lane_state [MAX_PROCESSORS];
  lane_act_t  lane_act [MAX_PROCESSORS];
  lane_cnt_t  lane_cnt [MAX_PROCESSORS];
  out_word_t  res;

  logic       out_valid_r, out_valid_nxt;
  logic       skid_valid_r, skid_valid_nxt;
  out_word_t  out_word_r, out_word_nxt;
  out_word_t  skid_word_r, skid_word_nxt;

  // Configuration registers, written on the APB access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      protocol_mode_r <= 2'd0;
      active_procs_r  <= 4'd4;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_PROTOCOL_MODE) begin
        protocol_mode_r <= pwdata[1:0];
      end else begin
        active_procs_r <= pwdata[3:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ACTIVE_PROCESSORS) ? {28'd0, active_procs_r}
                                                      : {30'd0, protocol_mode_r};

  assign in_ready = !skid_valid_r;
  assign in_acc   = in_valid && in_ready;
  assign upd      = (protocol_mode_r == PROTO_UPDATE);

  // One lane per cache; a lane snoops when active, present and not the requester.
  for (genvar g = 0; g < MAX_PROCESSORS; g++) begin : g_lane
    assign snoop[g] = (32'(active_procs_r) > g) && (32'(in_word.requester) != g)
                      && in_word.present_mask[g];

    scr_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .snoop     (snoop[g]),
      .fire      (in_acc),
      .upd       (upd),
      .kind      (in_word.kind),
      .state_in  (in_word.line_states[ST_W*g +: ST_W]),
      .state_out (lane_state[g]),
      .act       (lane_act[g]),
      .cnt       (lane_cnt[g])
    );
  end

  scr_merge #(
    .MAX_PROCESSORS (MAX_PROCESSORS)
  ) u_merge (
    .in_word    (in_word),
    .snoop      (snoop),
    .lane_state (lane_state),
    .lane_act   (lane_act),
    .lane_cnt   (lane_cnt),
    .res        (res)
  );

  // Output register with a one-word skid buffer behind it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_word_nxt   = out_word_r;
    skid_word_nxt  = skid_word_r;
    if (!out_valid_r || out_ready) begin
      out_valid_nxt  = skid_valid_r || in_acc;
      out_word_nxt   = skid_valid_r ? skid_word_r : res;
      skid_valid_nxt = 1'b0;
    end else if (in_acc) begin
      skid_valid_nxt = 1'b1;
      skid_word_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== sv/scr_checker.sv =====
// Port-level checker for the snoop responder, bound to the top level.
// Depends on scr_pkg and snoop_coherence_responder_core_macros.svh.
`include "snoop_coherence_responder_core_macros.svh"

module scr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input scr_pkg::in_word_t  in_word,
  input logic               out_valid,
  input logic               out_ready,
  input scr_pkg::out_word_t out_word
);
  import scr_pkg::*;

  // A stalled result word holds.
  `SCR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "result word changed while stalled")

  // With the output empty, an accepted word appears next cycle with its address.
  `SCR_ASSERT_NEXT(a_latency, in_valid && in_ready && !out_valid, out_valid && out_word.echo_address == $past(in_word.line_address), "accepted word not delivered next cycle")

  // Back-pressure on the input only while a result word is waiting.
  `SCR_ASSERT_NOW(a_ready_buffer, !in_ready, out_valid, "input stalled with empty output")

  // A write-back always comes with a flush, and any action implies a copy elsewhere.
  `SCR_ASSERT_NOW(a_masks, out_valid, ((out_word.writeback_mask & ~out_word.flush_mask) == 8'd0) && (((out_word.intervention_mask | out_word.flush_mask | out_word.invalidation_mask) == 8'd0) || out_word.copy_exists), "inconsistent action masks")

endmodule

bind snoop_coherence_responder_core scr_checker u_scr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);
